/* design/spa_pkg.sv */
// Shared types and constants for the sparse polynomial adder.
package spa_pkg;

	// Opcodes of an input item
	localparam logic [1:0] OP_LOAD_FIRST  = 2'd0;
	localparam logic [1:0] OP_LOAD_SECOND = 2'd1;
	localparam logic [1:0] OP_ADD         = 2'd2;

	// Depth of the command queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [1:0]          opcode;
		logic signed [15:0]  term_coeff;
		logic [15:0]         term_expo;
	} spa_in_t;

	typedef struct packed {
		logic signed [16:0]  sum_coeff;
		logic [15:0]         sum_expo;
		logic                last_term;
		logic                empty_sum;
		logic                overflow;
	} spa_out_t;

	typedef enum logic [1:0] {
		CMD_LOAD_FIRST,
		CMD_LOAD_SECOND,
		CMD_ADD
	} spa_cmd_kind_t;

	typedef struct packed {
		spa_cmd_kind_t       kind;
		logic signed [15:0]  coeff;
		logic [15:0]         expo;
	} spa_cmd_t;

	typedef struct packed {
		logic signed [15:0]  coeff;
		logic [15:0]         expo;
	} spa_term_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MERGE,
		ST_FLUSH
	} spa_state_t;

endpackage

/* design/spa_front.sv */
// Front end: accepts input items, decodes the opcode and registers a command.
module spa_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              term_valid,
	output logic              term_ready,
	input  spa_pkg::spa_in_t  term,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output spa_pkg::spa_cmd_t cmd
);
	import spa_pkg::*;

	logic     valid_s1;
	spa_cmd_t cmd_s1;
	logic     accept;
	logic     keep;
	spa_cmd_t decoded;

	assign term_ready = !valid_s1 || cmd_ready;
	assign accept     = term_valid && term_ready;

	// Decode: the unused opcode is swallowed here
	always_comb begin
		decoded       = '0;
		decoded.coeff = term.term_coeff;
		decoded.expo  = term.term_expo;
		keep          = 1'b1;
		unique case (term.opcode)
			OP_LOAD_FIRST:  decoded.kind = CMD_LOAD_FIRST;
			OP_LOAD_SECOND: decoded.kind = CMD_LOAD_SECOND;
			OP_ADD:         decoded.kind = CMD_ADD;
			default: begin
				decoded.kind = CMD_ADD;
				keep         = 1'b0;
			end
		endcase
	end

	// Command register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep;
		end else if (cmd_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= decoded;
		end
	end

	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

endmodule

/* design/spa_queue.sv */
// Short command queue that decouples the front end from the merge engine.
module spa_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  spa_pkg::spa_cmd_t push_cmd,
	output logic              pop_valid,
	input  logic              pop_ready,
	output spa_pkg::spa_cmd_t pop_cmd
);
	import spa_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	spa_cmd_t        slots_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   fill_q;
	logic            push;
	logic            pop;

	assign push_ready = (fill_q != CW'(QUEUE_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_cmd    = slots_q[rd_ptr_q];

	// Pointer wrap that holds for any depth
	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		logic [PW-1:0] r;
		if (p == PW'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PW'(1);
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

/* design/spa_back.sv */
// Back end: term stores, merge engine, one-term lookahead and output register.
module spa_back #(
	parameter int MAX_TERMS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  spa_pkg::spa_cmd_t cmd,
	output logic              sum_valid,
	input  logic              sum_ready,
	output spa_pkg::spa_out_t sum
);
	import spa_pkg::*;

	localparam int CW = $clog2(MAX_TERMS + 1);
	localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

	spa_term_t          first_mem  [MAX_TERMS];
	spa_term_t          second_mem [MAX_TERMS];

	spa_state_t         state_q, state_d;
	logic [CW-1:0]      first_cnt_q, first_cnt_d;
	logic [CW-1:0]      second_cnt_q, second_cnt_d;
	logic [CW-1:0]      i_q, i_d;
	logic [CW-1:0]      j_q, j_d;
	logic               dropped_q, dropped_d;
	logic               hold_valid_q, hold_valid_d;
	logic signed [16:0] hold_coeff_q, hold_coeff_d;
	logic [15:0]        hold_expo_q, hold_expo_d;
	logic               out_valid_q, out_valid_d;
	spa_out_t           out_q, out_d;

	logic               first_we;
	logic               second_we;
	logic               has_x;
	logic               has_y;
	spa_term_t          x;
	spa_term_t          y;
	logic signed [16:0] x_ext;
	logic signed [16:0] y_ext;
	logic signed [16:0] pair_sum;
	logic               cand_valid;
	logic signed [16:0] cand_coeff;
	logic [15:0]        cand_expo;
	logic               step_x;
	logic               step_y;
	logic               out_free;

	assign cmd_ready = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || sum_ready;

	// Store heads under the merge indexes
	assign has_x    = (i_q < first_cnt_q);
	assign has_y    = (j_q < second_cnt_q);
	assign x        = first_mem[i_q[IW-1:0]];
	assign y        = second_mem[j_q[IW-1:0]];
	assign x_ext    = {x.coeff[15], x.coeff};
	assign y_ext    = {y.coeff[15], y.coeff};
	assign pair_sum = x_ext + y_ext;

	// Merge step: pick the larger exponent, or add equal ones
	always_comb begin
		cand_valid = 1'b0;
		cand_coeff = x_ext;
		cand_expo  = x.expo;
		step_x     = 1'b0;
		step_y     = 1'b0;
		if (has_x && has_y) begin
			if (x.expo > y.expo) begin
				cand_valid = 1'b1;
				step_x     = 1'b1;
			end else if (x.expo < y.expo) begin
				cand_valid = 1'b1;
				cand_coeff = y_ext;
				cand_expo  = y.expo;
				step_y     = 1'b1;
			end else begin
				cand_valid = (pair_sum != '0);
				cand_coeff = pair_sum;
				step_x     = 1'b1;
				step_y     = 1'b1;
			end
		end else if (has_x) begin
			cand_valid = 1'b1;
			step_x     = 1'b1;
		end else if (has_y) begin
			cand_valid = 1'b1;
			cand_coeff = y_ext;
			cand_expo  = y.expo;
			step_y     = 1'b1;
		end
	end

	// Sequencer: next state, counters, lookahead and output register
	always_comb begin
		state_d      = state_q;
		first_cnt_d  = first_cnt_q;
		second_cnt_d = second_cnt_q;
		i_d          = i_q;
		j_d          = j_q;
		dropped_d    = dropped_q;
		hold_valid_d = hold_valid_q;
		hold_coeff_d = hold_coeff_q;
		hold_expo_d  = hold_expo_q;
		out_valid_d  = out_valid_q && !sum_ready;
		out_d        = out_q;
		first_we     = 1'b0;
		second_we    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.kind)
						CMD_LOAD_FIRST: begin
							if (first_cnt_q < CW'(MAX_TERMS)) begin
								first_we    = 1'b1;
								first_cnt_d = first_cnt_q + CW'(1);
							end else begin
								dropped_d = 1'b1;
							end
						end
						CMD_LOAD_SECOND: begin
							if (second_cnt_q < CW'(MAX_TERMS)) begin
								second_we    = 1'b1;
								second_cnt_d = second_cnt_q + CW'(1);
							end else begin
								dropped_d = 1'b1;
							end
						end
						CMD_ADD: begin
							i_d          = '0;
							j_d          = '0;
							hold_valid_d = 1'b0;
							state_d      = ST_MERGE;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_MERGE: begin
				if (!has_x && !has_y) begin
					state_d = ST_FLUSH;
				end else if (!(cand_valid && hold_valid_q) || out_free) begin
					if (step_x) begin
						i_d = i_q + CW'(1);
					end
					if (step_y) begin
						j_d = j_q + CW'(1);
					end
					if (cand_valid) begin
						// A new term proves the held one is not the last
						if (hold_valid_q) begin
							out_valid_d     = 1'b1;
							out_d.sum_coeff = hold_coeff_q;
							out_d.sum_expo  = hold_expo_q;
							out_d.last_term = 1'b0;
							out_d.empty_sum = 1'b0;
							out_d.overflow  = dropped_q;
						end
						hold_valid_d = 1'b1;
						hold_coeff_d = cand_coeff;
						hold_expo_d  = cand_expo;
					end
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					out_valid_d     = 1'b1;
					out_d.last_term = 1'b1;
					out_d.overflow  = dropped_q;
					if (hold_valid_q) begin
						out_d.sum_coeff = hold_coeff_q;
						out_d.sum_expo  = hold_expo_q;
						out_d.empty_sum = 1'b0;
					end else begin
						out_d.sum_coeff = '0;
						out_d.sum_expo  = '0;
						out_d.empty_sum = 1'b1;
					end
					first_cnt_d  = '0;
					second_cnt_d = '0;
					dropped_d    = 1'b0;
					hold_valid_d = 1'b0;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			first_cnt_q  <= '0;
			second_cnt_q <= '0;
			i_q          <= '0;
			j_q          <= '0;
			dropped_q    <= 1'b0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			first_cnt_q  <= first_cnt_d;
			second_cnt_q <= second_cnt_d;
			i_q          <= i_d;
			j_q          <= j_d;
			dropped_q    <= dropped_d;
			hold_valid_q <= hold_valid_d;
			out_valid_q  <= out_valid_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		hold_coeff_q <= hold_coeff_d;
		hold_expo_q  <= hold_expo_d;
		out_q        <= out_d;
	end

	// Term stores
	always_ff @(posedge clk) begin
		if (first_we) begin
			first_mem[first_cnt_q[IW-1:0]] <= '{coeff: cmd.coeff, expo: cmd.expo};
		end
		if (second_we) begin
			second_mem[second_cnt_q[IW-1:0]] <= '{coeff: cmd.coeff, expo: cmd.expo};
		end
	end

	assign sum_valid = out_valid_q;
	assign sum       = out_q;

endmodule

/* design/sparse_polynomial_add.sv */
// Sparse polynomial adder: loads one term per cycle while no add holds the merge engine.
// A load item is registered at the front, held in a queue slot, then written to its store (front, queue, back).
// An add passes the same path; its first result follows the merge lookahead and the output register.
// Throughput: one load per cycle while idle; merging takes one term or equal pair per cycle unless output stalls.
// Reset clears counts, overflow flag, queue and handshakes; term stores keep contents.
module sparse_polynomial_add #(
	parameter int MAX_TERMS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              term_valid,
	output logic              term_ready,
	input  spa_pkg::spa_in_t  term,
	output logic              sum_valid,
	input  logic              sum_ready,
	output spa_pkg::spa_out_t sum
);
	import spa_pkg::*;

	logic     front_valid;
	logic     front_ready;
	spa_cmd_t front_cmd;
	logic     back_valid;
	logic     back_ready;
	spa_cmd_t back_cmd;

	spa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.term_valid (term_valid),
		.term_ready (term_ready),
		.term       (term),
		.cmd_valid  (front_valid),
		.cmd_ready  (front_ready),
		.cmd        (front_cmd)
	);

	spa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_cmd   (front_cmd),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_cmd    (back_cmd)
	);

	spa_back #(
		.MAX_TERMS (MAX_TERMS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (back_valid),
		.cmd_ready (back_ready),
		.cmd       (back_cmd),
		.sum_valid (sum_valid),
		.sum_ready (sum_ready),
		.sum       (sum)
	);

endmodule
